// ===== rtl/tdp_pkg.sv =====
// Shared widths, microcode encodings and the control store of the prime tester.
package tdp_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int CAND_W      = 16;
  localparam int COUNT_W     = 8;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;
  localparam int BIT_W       = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int SQ_W        = VALUE_WIDTH + 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_WAIT,
    ST_TWO,
    ST_REJECT,
    ST_LOOP,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_TEST,
    ST_BACK,
    ST_NOT_PRIME,
    ST_EMIT,
    ST_DONE
  } step_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SET_PRIME,
    ACT_CLR_PRIME,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_NEXT_DIV,
    ACT_EMIT
  } act_t;

  typedef enum logic [3:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_REQ,
    JMP_IS_TWO,
    JMP_REJECT,
    JMP_SQ_GT,
    JMP_MORE_BITS,
    JMP_REM_ZERO,
    JMP_OUT_BUSY
  } jmp_t;

  typedef struct packed {
    act_t  act;
    jmp_t  jmp;
    step_t target;
  } uword_t;

  // Control store: jump to target when the condition holds, else fall through.
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    case (s)
      ST_WAIT:      w = '{ACT_LOAD,      JMP_NO_REQ,    ST_WAIT};
      ST_TWO:       w = '{ACT_SET_PRIME, JMP_IS_TWO,    ST_EMIT};
      ST_REJECT:    w = '{ACT_NONE,      JMP_REJECT,    ST_NOT_PRIME};
      ST_LOOP:      w = '{ACT_NONE,      JMP_SQ_GT,     ST_EMIT};
      ST_DIV_INIT:  w = '{ACT_DIV_INIT,  JMP_NEVER,     ST_WAIT};
      ST_DIV_STEP:  w = '{ACT_DIV_STEP,  JMP_MORE_BITS, ST_DIV_STEP};
      ST_TEST:      w = '{ACT_NEXT_DIV,  JMP_REM_ZERO,  ST_NOT_PRIME};
      ST_BACK:      w = '{ACT_NONE,      JMP_ALWAYS,    ST_LOOP};
      ST_NOT_PRIME: w = '{ACT_CLR_PRIME, JMP_ALWAYS,    ST_EMIT};
      ST_EMIT:      w = '{ACT_EMIT,      JMP_OUT_BUSY,  ST_EMIT};
      ST_DONE:      w = '{ACT_NONE,      JMP_ALWAYS,    ST_WAIT};
      default:      w = '{ACT_NONE,      JMP_ALWAYS,    ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/trial_division_prime_test.sv =====
// Top level: microcoded trial-division primality tester.
// Order of work: two is reported prime, and values below 3 or even are rejected without a
//   trial; an odd value runs one trial per odd divisor from 3 until one divides it or the
//   divisor's square exceeds it. A stalled output holds the result in the emit step.
// Requests: one at a time; the next is taken only after the result is registered. The
//   shared bit-serial remainder unit (one dividend bit per cycle) sets the time of each
//   trial.
// Reset: synchronous, active high; clears the step counter and the output valid.
module trial_division_prime_test (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tdp_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] candidate
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tdp_pkg::OUT_DATA_W-1:0]  m_tdata    // [0] is_prime, [8:1] trial_count, rest zero
);
  import tdp_pkg::*;

  // Step counter and the control word it addresses
  step_t  pc;
  uword_t uw;
  logic   jump;

  // Datapath registers
  logic [VALUE_WIDTH-1:0] cand;   // candidate, low VALUE_WIDTH bits
  logic [VALUE_WIDTH-1:0] div;    // current odd divisor
  logic [SQ_W-1:0]        sq;     // div * div, kept by increments
  logic [VALUE_WIDTH-1:0] rem;    // partial remainder of cand / div
  logic [BIT_W-1:0]       bidx;   // dividend bit fed this cycle
  logic [COUNT_W-1:0]     count;
  logic                   prime;

  // Output register
  logic                   out_prime;
  logic [COUNT_W-1:0]     out_count;

  logic                   req_accept;
  logic                   out_free;
  logic [VALUE_WIDTH:0]   shifted;
  logic                   fits;

  assign uw         = ucode_rom(pc);
  assign s_tready   = (pc == ST_WAIT);
  assign req_accept = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;

  // One restoring-division step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem, cand[bidx]};
  assign fits    = (shifted >= {1'b0, div});

  // Jump condition select
  always_comb begin
    case (uw.jmp)
      JMP_NEVER:     jump = 1'b0;
      JMP_ALWAYS:    jump = 1'b1;
      JMP_NO_REQ:    jump = !req_accept;
      JMP_IS_TWO:    jump = (cand == VALUE_WIDTH'(2));
      JMP_REJECT:    jump = (cand < VALUE_WIDTH'(3)) || !cand[0];
      JMP_SQ_GT:     jump = (sq > SQ_W'(cand));
      JMP_MORE_BITS: jump = (bidx != '0);
      JMP_REM_ZERO:  jump = (rem == '0);
      JMP_OUT_BUSY:  jump = !out_free;
      default:       jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= ST_WAIT;
      m_tvalid <= 1'b0;
    end else begin
      // Advance: take the jump or fall through to the next step
      pc <= jump ? uw.target : step_t'(pc + 1'b1);

      // Raise valid on an emit into a free register, else drop it once the consumer takes it
      if (uw.act == ACT_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (uw.act)
        ACT_LOAD: begin
          if (req_accept) begin
            cand  <= VALUE_WIDTH'(s_tdata);
            div   <= VALUE_WIDTH'(3);
            sq    <= SQ_W'(9);
            count <= '0;
          end
        end
        ACT_SET_PRIME: prime <= 1'b1;
        ACT_CLR_PRIME: prime <= 1'b0;
        ACT_DIV_INIT: begin
          rem  <= '0;
          bidx <= BIT_W'(VALUE_WIDTH - 1);
          if (count != COUNT_MAX) begin
            count <= count + 1'b1;
          end
        end
        ACT_DIV_STEP: begin
          rem  <= fits ? VALUE_WIDTH'(shifted - {1'b0, div}) : shifted[VALUE_WIDTH-1:0];
          bidx <= bidx - 1'b1;
        end
        ACT_NEXT_DIV: begin
          // (d+2)^2 = d^2 + 4d + 4
          div <= div + VALUE_WIDTH'(2);
          sq  <= sq + (SQ_W'(div) << 2) + SQ_W'(4);
        end
        ACT_EMIT: begin
          // Hold here until the output register is free
          if (out_free) begin
            out_prime <= prime;
            out_count <= count;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_tdata = {{(OUT_DATA_W - COUNT_W - 1){1'b0}}, out_count, out_prime};

endmodule

// ===== rtl/tdp_checker.sv =====
// Port-level checker for the prime tester, bound to the top level.
module tdp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tdp_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import tdp_pkg::*;

  // Only one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  // Reset leaves the block empty and ready for a request
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or vanished");

  // Pad bits above the trial count stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:COUNT_W+1] == '0)
    else $error("result pad bits not zero");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (.*);
